FILE: hdl/rpls_pkg.sv
// Shared types, register codes and constants of the row projection line segmenter.
`timescale 1ns / 1ps

package rpls_pkg;

  // Frame geometry limits
  localparam int unsigned MaxDim = 4096;
  localparam int unsigned IdxW   = 12;   // row and column index
  localparam int unsigned DimW   = 13;   // configured size, holds MaxDim
  localparam int unsigned CntW   = 13;   // dark count per row, saturates at MaxDim

  // Output field widths
  localparam int unsigned TopW    = 12;
  localparam int unsigned HeightW = 14;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CfgDarkThr  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSkipCnt  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinBand  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImgWidth = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgImgHgt   = 3'd4;

  // Register reset values
  localparam logic [7:0]      DarkThrRst  = 8'd130;
  localparam logic [11:0]     SkipCntRst  = 12'd92;
  localparam logic [11:0]     MinBandRst  = 12'd15;
  localparam logic [DimW-1:0] ImgWidthRst = 13'd640;
  localparam logic [DimW-1:0] ImgHgtRst   = 13'd480;

  // Result queue depth
  localparam int unsigned ResFifoDepth = 8;

  typedef struct packed {
    logic [7:0]      dark_thr;
    logic [11:0]     skip_cnt;
    logic [11:0]     min_band;
    logic [DimW-1:0] img_width;
    logic [DimW-1:0] img_height;
  } cfg_t;

  typedef struct packed {
    logic [TopW-1:0]           strip_top;
    logic signed [HeightW-1:0] strip_height;
    logic                      frame_final;
    logic                      last_of_run;
  } result_t;

  // Up to two results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: hdl/rpls_cfg_regs.sv
// Configuration register file of the row projection line segmenter.
`timescale 1ns / 1ps

module rpls_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpls_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpls_pkg::CfgDataW-1:0] cfg_data_i,
  output rpls_pkg::cfg_t                cfg_o
);

  rpls_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write request
  assign cfg_ready_o = 1'b1;

  // Decode the register index, drop unknown indexes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rpls_pkg::CfgDarkThr:  cfg_d.dark_thr   = cfg_data_i[7:0];
        rpls_pkg::CfgSkipCnt:  cfg_d.skip_cnt   = cfg_data_i[11:0];
        rpls_pkg::CfgMinBand:  cfg_d.min_band   = cfg_data_i[11:0];
        rpls_pkg::CfgImgWidth: cfg_d.img_width  = cfg_data_i;
        rpls_pkg::CfgImgHgt:   cfg_d.img_height = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_thr   <= rpls_pkg::DarkThrRst;
      cfg_q.skip_cnt   <= rpls_pkg::SkipCntRst;
      cfg_q.min_band   <= rpls_pkg::MinBandRst;
      cfg_q.img_width  <= rpls_pkg::ImgWidthRst;
      cfg_q.img_height <= rpls_pkg::ImgHgtRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/rpls_seg_core.sv
// Pixel input register, row projection and band segmentation state machine.
`timescale 1ns / 1ps

module rpls_seg_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rpls_pkg::cfg_t cfg_i,
  input  logic           in_acc_i,
  input  logic [7:0]     pixel_i,
  output logic           pend_o,
  output rpls_pkg::push_t push_o
);

  localparam int unsigned IdxW = rpls_pkg::IdxW;
  localparam int unsigned DimW = rpls_pkg::DimW;
  localparam int unsigned CntW = rpls_pkg::CntW;
  localparam logic [DimW-1:0] MaxDimV = DimW'(rpls_pkg::MaxDim);

  // Input register
  logic       pix_vld_q, pix_vld_d;
  logic [7:0] pix_q, pix_d;

  // Segmentation state
  logic [IdxW-1:0] col_q, col_d, row_q, row_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] bfr_q, bfr_d, blr_q, blr_d;
  logic [IdxW-1:0] frb_q, frb_d, lrb_q, lrb_d;
  logic [IdxW-1:0] ssr_q, ssr_d;
  logic            await_q, await_d, inband_q, inband_d;

  // Working values
  logic [DimW-1:0]        eff_w, eff_h;
  logic [CntW-1:0]        cnt_new;
  logic                   row_end, frame_end, occ, keep_band;
  logic signed [DimW-1:0] band_h;
  logic [DimW-1:0]        sum_mid;
  logic [IdxW-1:0]        mid;
  rpls_pkg::result_t      band_res, fin_res;
  logic                   band_emit;

  // Clamp configured sizes to 1..MaxDim
  always_comb begin
    if (cfg_i.img_width == '0) begin
      eff_w = DimW'(1);
    end else if (cfg_i.img_width > MaxDimV) begin
      eff_w = MaxDimV;
    end else begin
      eff_w = cfg_i.img_width;
    end
    if (cfg_i.img_height == '0) begin
      eff_h = DimW'(1);
    end else if (cfg_i.img_height > MaxDimV) begin
      eff_h = MaxDimV;
    end else begin
      eff_h = cfg_i.img_height;
    end
  end

  // Count dark pixel, detect row and frame end
  assign cnt_new = (pix_q <= cfg_i.dark_thr && cnt_q < CntW'(rpls_pkg::MaxDim))
                   ? cnt_q + CntW'(1) : cnt_q;
  assign row_end   = !(({1'b0, col_q} + DimW'(1)) < eff_w);
  assign frame_end = !(({1'b0, row_q} + DimW'(1)) < eff_h);
  assign occ       = cnt_new > ({1'b0, cfg_i.skip_cnt} + CntW'(1));
  assign band_h    = $signed({1'b0, row_q} - {1'b0, bfr_q});
  assign keep_band = band_h > $signed({1'b0, cfg_i.min_band});

  // Next state and results
  always_comb begin
    pix_vld_d = in_acc_i;
    pix_d     = in_acc_i ? pixel_i : pix_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    bfr_d     = bfr_q;
    blr_d     = blr_q;
    frb_d     = frb_q;
    lrb_d     = lrb_q;
    ssr_d     = ssr_q;
    await_d   = await_q;
    inband_d  = inband_q;
    sum_mid   = '0;
    mid       = '0;
    band_emit = 1'b0;
    band_res  = '0;
    fin_res   = '0;
    push_o    = '0;

    if (pix_vld_q) begin
      if (!row_end) begin
        col_d = col_q + IdxW'(1);
        cnt_d = cnt_new;
      end else begin
        // Band tracking at row end
        if (occ && await_q && !inband_q) begin
          bfr_d    = row_q;
          await_d  = 1'b0;
          inband_d = 1'b1;
        end else if (!occ && inband_q) begin
          if (keep_band) begin
            lrb_d = blr_q;
            blr_d = row_q;
          end else begin
            bfr_d   = frb_q;
            sum_mid = {1'b0, frb_q} + {1'b0, lrb_q};
            ssr_d   = sum_mid[DimW-1:1];
          end
          inband_d = 1'b0;
        end else if (occ && !inband_q && !await_q) begin
          frb_d     = bfr_q;
          bfr_d     = row_q;
          sum_mid   = {1'b0, row_q} + {1'b0, blr_q};
          mid       = sum_mid[DimW-1:1];
          band_emit = 1'b1;
          band_res.strip_top    = ssr_q;
          band_res.strip_height = $signed({2'b00, mid} - {2'b00, ssr_q});
          band_res.frame_final  = 1'b0;
          band_res.last_of_run  = !frame_end;
          ssr_d    = mid;
          inband_d = 1'b1;
        end

        col_d = '0;
        cnt_d = '0;

        if (!frame_end) begin
          row_d = row_q + IdxW'(1);
        end else begin
          // Closing strip, then start the next frame
          fin_res.strip_top    = ssr_d;
          fin_res.strip_height = $signed({1'b0, eff_h} - {2'b00, ssr_d});
          fin_res.frame_final  = 1'b1;
          fin_res.last_of_run  = 1'b1;
          row_d    = '0;
          bfr_d    = '0;
          blr_d    = '0;
          frb_d    = '0;
          lrb_d    = '0;
          ssr_d    = '0;
          await_d  = 1'b1;
          inband_d = 1'b0;
        end

        // Band strip goes first
        if (band_emit && frame_end) begin
          push_o.cnt = 2'd2;
          push_o.r0  = band_res;
          push_o.r1  = fin_res;
        end else if (band_emit) begin
          push_o.cnt = 2'd1;
          push_o.r0  = band_res;
        end else if (frame_end) begin
          push_o.cnt = 2'd1;
          push_o.r0  = fin_res;
        end
      end
    end
  end

  // Pixel payload register
  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_vld_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      cnt_q     <= '0;
      bfr_q     <= '0;
      blr_q     <= '0;
      frb_q     <= '0;
      lrb_q     <= '0;
      ssr_q     <= '0;
      await_q   <= 1'b1;
      inband_q  <= 1'b0;
    end else begin
      pix_vld_q <= pix_vld_d;
      col_q     <= col_d;
      row_q     <= row_d;
      cnt_q     <= cnt_d;
      bfr_q     <= bfr_d;
      blr_q     <= blr_d;
      frb_q     <= frb_d;
      lrb_q     <= lrb_d;
      ssr_q     <= ssr_d;
      await_q   <= await_d;
      inband_q  <= inband_d;
    end
  end

  assign pend_o = pix_vld_q;

endmodule

FILE: hdl/rpls_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per request.
`timescale 1ns / 1ps

module rpls_result_fifo #(
  parameter int unsigned Depth = rpls_pkg::ResFifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpls_pkg::push_t            push_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output rpls_pkg::result_t          head_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  rpls_pkg::result_t mem_q [Depth];

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr1, wr2;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Pointer arithmetic with wrap
  assign wr1 = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
  assign wr2 = (wr1 == LastPtr) ? '0 : wr1 + PtrW'(1);

  always_comb begin
    rd_d = rd_q;
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    case (push_i.cnt)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = wr2;
      default: wr_d = wr_q;
    endcase
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  // Store results
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      if (push_i.cnt != 2'd0 && wr_q == PtrW'(i)) begin
        mem_q[i] <= push_i.r0;
      end else if (push_i.cnt == 2'd2 && wr1 == PtrW'(i)) begin
        mem_q[i] <= push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: hdl/row_projection_line_segmenter_top.sv
// Top level of the row projection line segmenter.
//
// Pixels enter on in_valid_i / in_stall_o / pixel_i, one 8-bit gray value per
// request, in raster order. Line strips leave on out_valid_o / out_stall_i with
// strip_top_o, strip_height_o (signed), frame_final_o and last_of_run_o.
// A row end may give a band strip; the last row of a frame gives the closing
// strip, so one pixel causes at most two results, band strip first.
// Registers are written on cfg_valid_i / cfg_ready_o (always ready) with
// cfg_index_i and cfg_data_i; indexes above four are ignored.
// Throughput: one pixel per cycle while in_stall_o is low. A result enters
// the queue at the clock edge after the one that takes its pixel. Results queue in an
// eight-entry buffer; input is held off while the queued results, two for the
// pixel in the input register and two for a new pixel would overfill it, so
// only a stalled receiver costs input cycles.
// When the receiver stalls, the head result holds and the queue fills.
// Reset loads the register defaults, empties the queue and starts a new frame
// at row 0, column 0.
`timescale 1ns / 1ps

module row_projection_line_segmenter_top #(
  parameter int unsigned FifoDepth = rpls_pkg::ResFifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rpls_pkg::TopW-1:0]     strip_top_o,
  output logic signed [rpls_pkg::HeightW-1:0] strip_height_o,
  output logic                          frame_final_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpls_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rpls_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned FifoCntW = $clog2(FifoDepth + 1);
  localparam int unsigned LoadW    = FifoCntW + 1;

  rpls_pkg::cfg_t    cfg;
  rpls_pkg::push_t   push;
  rpls_pkg::result_t head;
  logic                in_acc, pend, pop;
  logic [FifoCntW-1:0] fifo_cnt;
  logic [LoadW-1:0]    load;

  rpls_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Hold off input unless the queue can take two more results beyond the two held for a pending pixel
  assign load       = {1'b0, fifo_cnt} + (pend ? LoadW'(2) : LoadW'(0));
  assign in_stall_o = load > LoadW'(FifoDepth - 2);
  assign in_acc     = in_valid_i && !in_stall_o;

  rpls_seg_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_acc_i (in_acc),
    .pixel_i  (pixel_i),
    .pend_o   (pend),
    .push_o   (push)
  );

  assign pop = out_valid_o && !out_stall_i;

  rpls_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (fifo_cnt)
  );

  assign strip_top_o    = head.strip_top;
  assign strip_height_o = head.strip_height;
  assign frame_final_o  = head.frame_final;
  assign last_of_run_o  = head.last_of_run;

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  // A pixel being processed always finds room for two results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend |-> (fifo_cnt <= FifoCntW'(FifoDepth - 2)))
    else $error("no room for results of pending pixel");

  // First of a result pair is always a band strip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> !frame_final_o)
    else $error("closing strip not last of its run");

  // Nothing is written to the queue without a pending pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend |-> (push.cnt == 2'd0))
    else $error("result written without a pixel");
`endif

endmodule

FILE: bench/rpls_strip_checker.sv
// Strip predictor and comparator for the row projection line segmenter bench.
`timescale 1ns / 1ps

module rpls_strip_checker
  import rpls_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [7:0]                pixel_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [TopW-1:0]           strip_top_i,
  input  logic signed [HeightW-1:0] strip_height_i,
  input  logic                      frame_final_i,
  input  logic                      last_of_run_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  output int                        strips_pending_o,
  output int                        strip_errors_o
);

  // Register copies
  logic [7:0]      thr_r;
  logic [11:0]     skip_r;
  logic [11:0]     min_band_r;
  logic [DimW-1:0] width_r;
  logic [DimW-1:0] height_r;

  // Segmentation state
  logic [IdxW-1:0] col_idx;
  logic [IdxW-1:0] row_idx;
  logic [CntW-1:0] dark_cnt;
  logic [IdxW-1:0] band_first;
  logic [IdxW-1:0] band_last;
  logic [IdxW-1:0] first_bak;
  logic [IdxW-1:0] last_bak;
  logic [IdxW-1:0] strip_start;
  bit              awaiting_first;
  bit              in_band;

  result_t strips_due[$];
  int      mismatches = 0;

  assign strip_errors_o = mismatches;

  // Zero acts as one, anything above the maximum as the maximum
  function automatic int dim_of(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > DimW'(MaxDim)) return int'(MaxDim);
    return int'(v);
  endfunction

  task automatic restart_frame();
    col_idx        = '0;
    row_idx        = '0;
    dark_cnt       = '0;
    band_first     = '0;
    band_last      = '0;
    first_bak      = '0;
    last_bak       = '0;
    strip_start    = '0;
    awaiting_first = 1'b1;
    in_band        = 1'b0;
  endtask

  // Advance the segmenter by one pixel and queue the strips it closes
  task automatic segment_pixel(input logic [7:0] px);
    bit      occupied;
    int      mid;
    result_t s;
    result_t run_q[$];
    if (px <= thr_r && dark_cnt < CntW'(MaxDim)) dark_cnt = dark_cnt + 1'b1;
    if (int'(col_idx) + 1 < dim_of(width_r)) begin
      col_idx = col_idx + 1'b1;
      return;
    end
    occupied = int'(dark_cnt) > int'(skip_r) + 1;
    if (occupied && awaiting_first && !in_band) begin
      band_first     = row_idx;
      awaiting_first = 1'b0;
      in_band        = 1'b1;
    end else if (!occupied && in_band) begin
      // keep a tall band, fall back to the backups on a short one
      if (int'(row_idx) - int'(band_first) > int'(min_band_r)) begin
        last_bak  = band_last;
        band_last = row_idx;
      end else begin
        band_first  = first_bak;
        strip_start = IdxW'((int'(band_first) + int'(last_bak)) / 2);
      end
      in_band = 1'b0;
    end else if (occupied && !in_band && !awaiting_first) begin
      first_bak      = band_first;
      band_first     = row_idx;
      mid            = (int'(band_first) + int'(band_last)) / 2;
      s.strip_top    = strip_start;
      s.strip_height = HeightW'(mid - int'(strip_start));
      s.frame_final  = 1'b0;
      s.last_of_run  = 1'b0;
      run_q.insert(run_q.size(), s);
      strip_start = IdxW'(mid);
      in_band     = 1'b1;
    end
    col_idx  = '0;
    dark_cnt = '0;
    if (int'(row_idx) + 1 < dim_of(height_r)) begin
      row_idx = row_idx + 1'b1;
    end else begin
      s.strip_top    = strip_start;
      s.strip_height = HeightW'(dim_of(height_r) - int'(strip_start));
      s.frame_final  = 1'b1;
      s.last_of_run  = 1'b0;
      run_q.insert(run_q.size(), s);
      restart_frame();
    end
    if (run_q.size() != 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[i]) strips_due.insert(strips_due.size(), run_q[i]);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Track register writes, predict on pixel requests, compare strip requests
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      thr_r      = DarkThrRst;
      skip_r     = SkipCntRst;
      min_band_r = MinBandRst;
      width_r    = ImgWidthRst;
      height_r   = ImgHgtRst;
      restart_frame();
      strips_due.delete();
      strips_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDarkThr:  thr_r      = cfg_data_i[7:0];
          CfgSkipCnt:  skip_r     = cfg_data_i[11:0];
          CfgMinBand:  min_band_r = cfg_data_i[11:0];
          CfgImgWidth: width_r    = cfg_data_i[DimW-1:0];
          CfgImgHgt:   height_r   = cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) segment_pixel(pixel_i);
      if (out_valid_i && !out_stall_i) begin
        if (strips_due.size() == 0) begin
          $error("strip with none expected: top %0d height %0d final %0b last %0b",
                 strip_top_i, strip_height_i, frame_final_i, last_of_run_i);
          mismatches++;
        end else begin
          want = strips_due.pop_front();
          check_field("strip_top", 32'(want.strip_top), 32'(strip_top_i));
          check_field("strip_height", 32'($signed(want.strip_height)),
                      32'($signed(strip_height_i)));
          check_field("frame_final", 32'(want.frame_final), 32'(frame_final_i));
          check_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run_i));
        end
      end
      strips_pending_o <= strips_due.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Stimulus, clocking and verdict for the row projection line segmenter bench.
`timescale 1ns / 1ps

module tb_top;
  import rpls_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgNoReg = 3'd7;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic [7:0]                pixel       = 8'd0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [TopW-1:0]           strip_top;
  logic signed [HeightW-1:0] strip_height;
  logic                      frame_final;
  logic                      last_of_run;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CfgIdxW-1:0]        cfg_index   = '0;
  logic [CfgDataW-1:0]       cfg_data    = '0;

  int strips_pending;
  int strip_errors;
  int stall_hold  = 0;

  logic [7:0]          pix_q[$];
  logic [CfgIdxW-1:0]  reg_idx_q[$];
  logic [CfgDataW-1:0] reg_val_q[$];

  row_projection_line_segmenter_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pixel_i        (pixel),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .strip_top_o    (strip_top),
    .strip_height_o (strip_height),
    .frame_final_o  (frame_final),
    .last_of_run_o  (last_of_run),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  rpls_strip_checker u_strip_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .pixel_i          (pixel),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .strip_top_i      (strip_top),
    .strip_height_i   (strip_height),
    .frame_final_i    (frame_final),
    .last_of_run_i    (last_of_run),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .strips_pending_o (strips_pending),
    .strip_errors_o   (strip_errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop for a hung run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stall pattern: quiet stretches, solid stalls and choppy spells
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(40, 120);
        end
        1: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(0, 5);
        end
        default: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_hold <= $urandom_range(0, 3);
        end
      endcase
    end
  end

  // Wait for every expected strip, then let the pipeline drain
  task automatic wait_idle();
    @(posedge clk_i);
    while (strips_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    reg_idx_q.insert(reg_idx_q.size(), idx);
    reg_val_q.insert(reg_val_q.size(), CfgDataW'(val));
  endtask

  // Send the queued register writes once the block is idle
  task automatic write_regs();
    wait_idle();
    foreach (reg_idx_q[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_q[i];
      cfg_data  <= reg_val_q[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    reg_idx_q.delete();
    reg_val_q.delete();
  endtask

  // Send the queued pixels in bursts with gaps between them
  task automatic drive_pixels();
    int unsigned burst;
    burst = 0;
    foreach (pix_q[i]) begin
      if (burst == 0) begin
        if (i != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      end
      in_valid <= 1'b1;
      pixel    <= pix_q[i];
      do @(posedge clk_i); while (in_stall);
      burst--;
    end
    in_valid <= 1'b0;
    pix_q.delete();
  endtask

  // Add one row: mostly dark in a band, mostly light outside, some noise
  task automatic add_row(input bit busy, input int unsigned w, input logic [7:0] thr);
    logic [7:0] v;
    repeat (w) begin
      if ($urandom_range(0, 9) == 0) v = 8'($urandom_range(0, 255));
      else if (busy ^ ($urandom_range(0, 7) == 0)) v = 8'($urandom_range(0, thr));
      else if (thr == 8'hFF) v = 8'hFF;
      else v = 8'($urandom_range(int'(thr) + 1, 255));
      pix_q.insert(pix_q.size(), v);
    end
  endtask

  // Add whole frames with alternating runs of band and gap rows
  task automatic add_frames(input int unsigned frames, input int unsigned w,
                            input int unsigned h, input logic [7:0] thr);
    bit          busy;
    int unsigned run;
    busy = 1'($urandom_range(0, 1));
    run  = $urandom_range(1, 6);
    repeat (frames * h) begin
      add_row(busy, w, thr);
      run--;
      if (run == 0) begin
        busy = !busy;
        run  = $urandom_range(1, 6);
      end
    end
  endtask

  initial begin
    int unsigned cur_w, cur_h, random_pixels;
    logic [7:0]  cur_thr;
    int unsigned skip, band;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Band strip and closing strip from the same pixel, threshold boundary
    queue_reg(CfgDarkThr, 254);
    queue_reg(CfgSkipCnt, 0);
    queue_reg(CfgMinBand, 0);
    queue_reg(CfgImgWidth, 2);
    queue_reg(CfgImgHgt, 4);
    write_regs();
    pix_q = '{8'd254, 8'd0, 8'd255, 8'd255, 8'd255, 8'd200, 8'd0, 8'd1};
    drive_pixels();

    // Zero sizes act as one: each pixel closes a frame; unused index ignored
    queue_reg(CfgImgWidth, 0);
    queue_reg(CfgImgHgt, 0);
    queue_reg(CfgNoReg, 8191);
    write_regs();
    pix_q = '{8'd0, 8'd255, 8'd128};
    drive_pixels();

    // Shrink width and height mid-frame; the closing strip goes negative
    queue_reg(CfgDarkThr, 130);
    queue_reg(CfgImgWidth, 2);
    queue_reg(CfgImgHgt, 8);
    write_regs();
    pix_q = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd3, 8'd130, 8'd131, 8'd200,
              8'd0, 8'd1, 8'd255};
    drive_pixels();
    queue_reg(CfgImgWidth, 1);
    queue_reg(CfgImgHgt, 1);
    write_regs();
    pix_q = '{8'd254};
    drive_pixels();

    // Random phases of small frames; phases may end in the middle of a frame
    cur_w         = 1;
    cur_h         = 1;
    cur_thr       = 8'd130;
    random_pixels = 0;
    while (random_pixels < 500) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 7))
          0:       cur_thr = 8'd0;
          1:       cur_thr = 8'd255;
          default: cur_thr = 8'($urandom_range(0, 255));
        endcase
        queue_reg(CfgDarkThr, cur_thr);
      end
      if ($urandom_range(0, 4) != 0) begin
        cur_w = $urandom_range(1, 7);
        queue_reg(CfgImgWidth, cur_w);
      end
      if ($urandom_range(0, 4) != 0) begin
        cur_h = $urandom_range(1, 14);
        queue_reg(CfgImgHgt, cur_h);
      end
      if ($urandom_range(0, 4) != 0) begin
        skip = ($urandom_range(0, 9) == 0) ? 4095 :
               $urandom_range(0, (cur_w > 2) ? cur_w - 2 : 0);
        queue_reg(CfgSkipCnt, skip);
      end
      if ($urandom_range(0, 4) != 0) begin
        band = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 3);
        queue_reg(CfgMinBand, band);
      end
      if ($urandom_range(0, 9) == 0) queue_reg(CfgNoReg, $urandom_range(0, 8191));
      write_regs();
      add_frames($urandom_range(1, 2), cur_w, cur_h, cur_thr);
      if ($urandom_range(0, 1) != 0)
        add_row(1'($urandom_range(0, 1)), $urandom_range(0, cur_w * cur_h - 1), cur_thr);
      random_pixels += pix_q.size();
      drive_pixels();
    end

    // Close any open frame with a single-pixel frame
    queue_reg(CfgImgWidth, 0);
    queue_reg(CfgImgHgt, 0);
    write_regs();
    pix_q = '{8'd77};
    drive_pixels();

    wait_idle();
    if (strip_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
